// File: sv/cwi_pkg.sv
// Shared types, codes and helper functions for the cheat code write intercept block.
package cwi_pkg;

   localparam int MAX_ENTRIES_DEF = 128;
   localparam int IDX_W = 7;
   localparam int CMP_W = 8;
   localparam int GATHER_GROUP = 8;

   localparam logic [2:0] REQ_ADD = 3'd0;
   localparam logic [2:0] REQ_CLEAR = 3'd1;
   localparam logic [2:0] REQ_APPLY = 3'd2;
   localparam logic [2:0] REQ_RESTORE = 3'd3;
   localparam logic [2:0] REQ_BUS = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

   localparam logic [7:0] CODE_ONCE = 8'h00;
   localparam logic [7:0] CODE_BUS = 8'h01;
   localparam logic [7:0] CODE_BANK_LO = 8'h90;
   localparam logic [7:0] CODE_BANK_HI = 8'h97;
   localparam logic [3:0] WRAM_PAGE = 4'hD;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOOKUP,
      CMD_ADD,
      CMD_CLEAR,
      CMD_APPLY,
      CMD_SAVE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic bus;
      logic [IDX_W-1:0] idx;
      logic [15:0] addr;
      logic [7:0] code;
      logic [7:0] value;
      logic [7:0] data;
      logic keep_owner;
      logic save_en;
   } cell_cmd_type;

   typedef struct packed {
      logic hit;
      logic [7:0] code;
      logic [7:0] value;
      logic [15:0] addr;
      logic [7:0] saved;
      logic enabled;
   } cell_rd_type;

   localparam int RD_W = $bits(cell_rd_type);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] code;
      logic [7:0] value;
      logic [15:0] addr;
      logic [7:0] wdata;
      logic [2:0] bank;
      logic [IDX_W-1:0] idx;
      logic [7:0] rdval;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic write_valid;
      logic write_target;
      logic [15:0] write_address;
      logic [7:0] write_value;
      logic substituted;
   } rsp_item_type;

   function automatic logic is_banked(input logic [7:0] code);
      return code inside {[CODE_BANK_LO:CODE_BANK_HI]};
   endfunction

   function automatic logic in_work_ram(input logic [15:0] addr);
      return addr[15:12] == WRAM_PAGE;
   endfunction

endpackage

// File: sv/cwi_cell.sv
// One cheat table cell: holds an entry and its address ownership flag.
module cwi_cell #(
   parameter int CellId = 0
) (
   input logic clock,
   input logic reset,
   input cwi_pkg::cell_cmd_type cmd,
   output cwi_pkg::cell_rd_type rd
);

   logic [7:0] code_ff;
   logic [7:0] value_ff;
   logic [15:0] addr_ff;
   logic [7:0] saved_ff;
   logic enabled_ff;
   logic owner_ff;
   logic sel_ff;
   cwi_pkg::cell_rd_type rd_ff;

   logic id_match;
   logic addr_match;
   logic sel_in;

   assign id_match = cmd.idx == cwi_pkg::IDX_W'(CellId);
   assign addr_match = addr_ff == cmd.addr;
   assign sel_in = cmd.bus ? (owner_ff && addr_match) : id_match;
   assign rd = rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.kind == cwi_pkg::CMD_LOOKUP) begin
         rd_ff.hit <= sel_in;
         rd_ff.code <= sel_in ? code_ff : '0;
         rd_ff.value <= sel_in ? value_ff : '0;
         rd_ff.addr <= sel_in ? addr_ff : '0;
         rd_ff.saved <= sel_in ? saved_ff : '0;
         rd_ff.enabled <= sel_in & enabled_ff;
      end
      if (cmd.kind == cwi_pkg::CMD_ADD && id_match) begin
         code_ff <= cmd.code;
         value_ff <= cmd.value;
         addr_ff <= cmd.addr;
      end
      if (cmd.kind == cwi_pkg::CMD_APPLY && id_match && cmd.save_en) begin
         saved_ff <= cmd.data;
      end
      if (cmd.kind == cwi_pkg::CMD_SAVE && sel_ff) begin
         saved_ff <= cmd.data;
      end
      if (reset) begin
         enabled_ff <= 1'b0;
         owner_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         case (cmd.kind)
            cwi_pkg::CMD_LOOKUP: begin
               sel_ff <= sel_in;
            end
            cwi_pkg::CMD_ADD: begin
               if (id_match) begin
                  enabled_ff <= 1'b1;
                  owner_ff <= 1'b0;
               end
            end
            cwi_pkg::CMD_CLEAR: begin
               enabled_ff <= 1'b0;
               owner_ff <= 1'b0;
            end
            cwi_pkg::CMD_APPLY: begin
               if (id_match) begin
                  owner_ff <= cmd.keep_owner;
                  if (!cmd.keep_owner) begin
                     enabled_ff <= 1'b0;
                  end
               end else if (addr_match) begin
                  owner_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: sv/cwi_gather.sv
// Two-stage registered OR tree that collects the one selected cell's fields.
module cwi_gather #(
   parameter int NumCells = cwi_pkg::MAX_ENTRIES_DEF
) (
   input logic clock,
   input cwi_pkg::cell_rd_type rd_in [NumCells],
   output cwi_pkg::cell_rd_type rd_out
);

   localparam int NumGroups = (NumCells + cwi_pkg::GATHER_GROUP - 1) / cwi_pkg::GATHER_GROUP;
   localparam int PadCells = NumGroups * cwi_pkg::GATHER_GROUP;

   logic [cwi_pkg::RD_W-1:0] padded [PadCells];
   logic [cwi_pkg::RD_W-1:0] group_in [NumGroups];
   logic [cwi_pkg::RD_W-1:0] group_ff [NumGroups];
   logic [cwi_pkg::RD_W-1:0] total_in;
   logic [cwi_pkg::RD_W-1:0] total_ff;

   for (genvar i = 0; i < PadCells; i++) begin : g_pad
      if (i < NumCells) begin : g_real
         assign padded[i] = rd_in[i];
      end else begin : g_zero
         assign padded[i] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < cwi_pkg::GATHER_GROUP; k++) begin
            group_in[g] = group_in[g] | padded[g * cwi_pkg::GATHER_GROUP + k];
         end
      end
      total_in = '0;
      for (int g = 0; g < NumGroups; g++) begin
         total_in = total_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      total_ff <= total_in;
   end

   assign rd_out = total_ff;

endmodule

// File: sv/cheat_code_write_intercept.sv
// Top level of the cheat code write intercept: request sequencer, cell row and result register.
//
// Requests arrive on the req_ stream; the kind of request travels in req_tuser and its
// fields in req_tdata. Every request yields exactly one result transfer on the rsp_ stream.
// A request is broadcast to a row of MaxEntries cells, each holding one cheat entry and a
// flag saying it owns its address for write interception. The selected cell's fields come
// back through a two-stage registered OR tree, the result is formed, and the update is
// broadcast to the cells in the same cycle that the result is registered.
// An item passes from its transfer to its result being presented through cell lookup, two
// tree stages and commit. The sequencer handles one item at a time and takes the next
// one in the cycle after the commit, so a new request is not taken before the last one
// is committed.
// The result sits in an output register; the next request is taken while it waits, and
// a stalled receiver holds only the commit of the following item.
// Reset empties the table, disables every entry and clears all address ownership at once.
module cheat_code_write_intercept #(
   parameter int MaxEntries = cwi_pkg::MAX_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: entry_code, entry_value, address, write_data, ram_bank,
   // entry_index, read_value, then zero fill.
   input logic [63:0] req_tdata,
   // Fields from bit 0: req_type.
   input logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // Fields from bit 0: status, write_valid, write_target, write_address, write_value,
   // substituted, then zero fill.
   output logic [31:0] rsp_tdata
);

   localparam int CntW = $clog2(MaxEntries + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_GATHER1,
      ST_GATHER2,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic rsp_valid_ff;
   cwi_pkg::rsp_item_type rsp_data_ff;
   cwi_pkg::rsp_item_type res_in;
   cwi_pkg::req_item_type req_ff;
   cwi_pkg::req_item_type req_in;
   cwi_pkg::cell_cmd_type cmd;
   cwi_pkg::cell_cmd_type commit_cmd;
   cwi_pkg::cell_rd_type cell_rd [MaxEntries];
   cwi_pkg::cell_rd_type g;

   logic accept;
   logic out_free;
   logic commit;
   logic g_banked;
   logic g_known;
   logic g_wram;
   logic [15:0] emit_addr;
   logic idx_bad;
   logic full;

   assign req_in.kind = req_tuser;
   assign req_in.code = req_tdata[7:0];
   assign req_in.value = req_tdata[15:8];
   assign req_in.addr = req_tdata[31:16];
   assign req_in.wdata = req_tdata[39:32];
   assign req_in.bank = req_tdata[42:40];
   assign req_in.idx = req_tdata[49:43];
   assign req_in.rdval = req_tdata[57:50];

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit = (state_ff == ST_COMMIT) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_data_ff.substituted, rsp_data_ff.write_value,
                       rsp_data_ff.write_address, rsp_data_ff.write_target,
                       rsp_data_ff.write_valid, rsp_data_ff.status};

   for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
      cwi_cell #(
         .CellId(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .rd(cell_rd[i])
      );
   end

   cwi_gather #(
      .NumCells(MaxEntries)
   ) u_gather (
      .clock(clock),
      .rd_in(cell_rd),
      .rd_out(g)
   );

   assign g_banked = cwi_pkg::is_banked(g.code);
   assign g_known = (g.code == cwi_pkg::CODE_BUS) || g_banked;
   assign g_wram = g_banked && cwi_pkg::in_work_ram(g.addr);
   assign emit_addr = g_wram ? {1'b0, g.code[2:0], g.addr[11:0]} : g.addr;
   assign idx_bad = cwi_pkg::CMP_W'(req_ff.idx) >= cwi_pkg::CMP_W'(count_ff);
   assign full = count_ff >= CntW'(MaxEntries);

   always_comb begin
      res_in = '0;
      commit_cmd = '0;
      commit_cmd.kind = cwi_pkg::CMD_NONE;
      count_in = count_ff;
      case (req_ff.kind)
         cwi_pkg::REQ_ADD: begin
            if (full) begin
               res_in.status = cwi_pkg::STATUS_FULL;
            end else begin
               commit_cmd.kind = cwi_pkg::CMD_ADD;
               commit_cmd.idx = cwi_pkg::IDX_W'(count_ff);
               commit_cmd.code = req_ff.code;
               commit_cmd.value = req_ff.value;
               commit_cmd.addr = req_ff.addr;
               count_in = count_ff + CntW'(1);
            end
         end
         cwi_pkg::REQ_CLEAR: begin
            commit_cmd.kind = cwi_pkg::CMD_CLEAR;
            count_in = '0;
         end
         cwi_pkg::REQ_APPLY: begin
            if (idx_bad) begin
               res_in.status = cwi_pkg::STATUS_NOT_LOADED;
            end else if (g.enabled) begin
               commit_cmd.kind = cwi_pkg::CMD_APPLY;
               commit_cmd.idx = req_ff.idx;
               commit_cmd.addr = g.addr;
               commit_cmd.data = req_ff.rdval;
               if (g.code == cwi_pkg::CODE_ONCE) begin
                  commit_cmd.keep_owner = 1'b0;
                  res_in.write_valid = 1'b1;
                  res_in.write_address = g.addr;
                  res_in.write_value = g.value;
               end else begin
                  commit_cmd.keep_owner = 1'b1;
                  if (g_known) begin
                     commit_cmd.save_en = 1'b1;
                     res_in.write_valid = 1'b1;
                     res_in.write_target = g_wram;
                     res_in.write_address = emit_addr;
                     res_in.write_value = g.value;
                  end
               end
            end
         end
         cwi_pkg::REQ_RESTORE: begin
            if (idx_bad) begin
               res_in.status = cwi_pkg::STATUS_NOT_LOADED;
            end else if (g.enabled && g_known) begin
               res_in.write_valid = 1'b1;
               res_in.write_target = g_wram;
               res_in.write_address = emit_addr;
               res_in.write_value = g.saved;
            end
         end
         cwi_pkg::REQ_BUS: begin
            res_in.write_valid = 1'b1;
            res_in.write_address = req_ff.addr;
            res_in.write_value = req_ff.wdata;
            if (g.hit && ((g.code == cwi_pkg::CODE_BUS) ||
                          (g_banked && (!cwi_pkg::in_work_ram(req_ff.addr) ||
                                        req_ff.bank == g.code[2:0])))) begin
               res_in.write_value = g.value;
               res_in.substituted = 1'b1;
               commit_cmd.kind = cwi_pkg::CMD_SAVE;
               commit_cmd.data = req_ff.wdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.kind = cwi_pkg::CMD_NONE;
      if (state_ff == ST_LOOKUP) begin
         cmd.kind = cwi_pkg::CMD_LOOKUP;
         cmd.bus = req_ff.kind == cwi_pkg::REQ_BUS;
         cmd.idx = req_ff.idx;
         cmd.addr = req_ff.addr;
      end else if (commit) begin
         cmd = commit_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (commit) begin
         rsp_data_ff <= res_in;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_GATHER1;
            end
            ST_GATHER1: begin
               state_ff <= ST_GATHER2;
            end
            ST_GATHER2: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  count_ff <= count_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cheat code write intercept block.
module tb;
   import cwi_pkg::*;

   localparam logic [15:0] WRAM_LO = 16'hD000;
   localparam logic [15:0] WRAM_END = 16'hE000;
   localparam int BANK_SPAN = 'h1000;
   localparam logic [7:0] CODE_ODD = 8'h55;
   localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
   localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
   localparam int ADDR_HISTORY = 32;
   localparam int STALL_CYCLES = 150;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int send_idle_pct = 31;
   int recv_idle_pct = 62;
   bit hold_rsp = 1'b0;
   int mismatch_count = 0;
   rsp_item_type pending_results[$];

   int unsigned tbl_count = 0;
   logic [7:0] tbl_code [MAX_ENTRIES_DEF];
   logic [7:0] tbl_value [MAX_ENTRIES_DEF];
   logic [15:0] tbl_addr [MAX_ENTRIES_DEF];
   logic [7:0] tbl_saved [MAX_ENTRIES_DEF];
   bit tbl_en [MAX_ENTRIES_DEF];
   bit saved_known [MAX_ENTRIES_DEF];
   logic [6:0] owner_of [bit [15:0]];
   logic [15:0] applied_addrs[$];

   cheat_code_write_intercept dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit bank_code(input logic [7:0] c);
      return c >= CODE_BANK_LO && c <= CODE_BANK_HI;
   endfunction

   function automatic bit wram_window(input logic [15:0] a);
      return a >= WRAM_LO && a < WRAM_END;
   endfunction

   function automatic rsp_item_type entry_write_command(input logic [6:0] i,
                                                        input logic [7:0] v);
      rsp_item_type res;
      res = '0;
      res.write_valid = 1'b1;
      res.write_value = v;
      if (bank_code(tbl_code[i]) && wram_window(tbl_addr[i])) begin
         res.write_target = 1'b1;
         res.write_address = 16'((tbl_code[i] - CODE_BANK_LO) * BANK_SPAN
                                 + (tbl_addr[i] - WRAM_LO));
      end else begin
         res.write_address = tbl_addr[i];
      end
      return res;
   endfunction

   function automatic rsp_item_type intercept_predict(input req_item_type it);
      rsp_item_type res;
      logic [7:0] c;
      logic [15:0] a;
      logic [6:0] e;
      logic [6:0] n;
      bit hit;
      res = '0;
      n = 7'(tbl_count);
      case (it.kind)
         REQ_ADD: begin
            if (tbl_count >= MAX_ENTRIES_DEF) begin
               res.status = STATUS_FULL;
            end else begin
               tbl_code[n] = it.code;
               tbl_value[n] = it.value;
               tbl_addr[n] = it.addr;
               tbl_en[n] = 1'b1;
               saved_known[n] = 1'b0;
               tbl_count++;
            end
         end
         REQ_CLEAR: begin
            tbl_count = 0;
            foreach (tbl_en[i]) tbl_en[i] = 1'b0;
            owner_of.delete();
            applied_addrs.delete();
         end
         REQ_APPLY, REQ_RESTORE: begin
            if (32'(it.idx) >= tbl_count) begin
               res.status = STATUS_NOT_LOADED;
            end else if (tbl_en[it.idx]) begin
               c = tbl_code[it.idx];
               a = tbl_addr[it.idx];
               if (it.kind == REQ_APPLY) begin
                  owner_of[a] = it.idx;
                  applied_addrs.push_back(a);
                  if (applied_addrs.size() > ADDR_HISTORY) void'(applied_addrs.pop_front());
                  if (c == CODE_ONCE) begin
                     res.write_valid = 1'b1;
                     res.write_address = a;
                     res.write_value = tbl_value[it.idx];
                     tbl_en[it.idx] = 1'b0;
                     owner_of.delete(a);
                  end else if (c == CODE_BUS || bank_code(c)) begin
                     tbl_saved[it.idx] = it.rdval;
                     saved_known[it.idx] = 1'b1;
                     res = entry_write_command(it.idx, tbl_value[it.idx]);
                  end
               end else if (c == CODE_BUS || bank_code(c)) begin
                  res = entry_write_command(it.idx, tbl_saved[it.idx]);
               end
            end
         end
         REQ_BUS: begin
            res.write_valid = 1'b1;
            res.write_address = it.addr;
            res.write_value = it.wdata;
            if (owner_of.exists(it.addr)) begin
               e = owner_of[it.addr];
               c = tbl_code[e];
               hit = (c == CODE_BUS) || (bank_code(c) && (!wram_window(it.addr)
                     || it.bank == 3'(c - CODE_BANK_LO)));
               if (hit) begin
                  tbl_saved[e] = it.wdata;
                  saved_known[e] = 1'b1;
                  res.write_value = tbl_value[e];
                  res.substituted = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_item_type random_add();
      req_item_type it;
      int unsigned roll;
      it.kind = REQ_ADD;
      it.code = 8'($urandom_range(255));
      it.value = 8'($urandom_range(255));
      it.addr = 16'($urandom_range(16'hFFFF));
      it.wdata = 8'($urandom_range(255));
      it.bank = 3'($urandom_range(7));
      it.idx = 7'($urandom_range(127));
      it.rdval = 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 10) it.code = CODE_ONCE;
      else if (roll < 40) it.code = CODE_BUS;
      else if (roll < 80) it.code = CODE_BANK_LO + 8'($urandom_range(7));
      roll = $urandom_range(99);
      if (roll < 5) begin
         case ($urandom_range(3))
            0: it.addr = WRAM_LO - 16'd1;
            1: it.addr = WRAM_LO;
            2: it.addr = WRAM_END - 16'd1;
            default: it.addr = WRAM_END;
         endcase
      end else if (roll < 30) begin
         it.addr = WRAM_LO + 16'($urandom_range(15));
      end else if (roll < 45) begin
         it.addr = WRAM_LO + 16'($urandom_range(BANK_SPAN - 1));
      end else if (roll < 70) begin
         it.addr = 16'hA000 + 16'($urandom_range(15));
      end
      return it;
   endfunction

   function automatic req_item_type random_request();
      req_item_type it;
      int unsigned roll;
      logic [6:0] owner;
      it = random_add();
      roll = $urandom_range(99);
      if (roll < 4) begin
         it.kind = REQ_CLEAR;
      end else if (roll < 26) begin
         it.kind = REQ_ADD;
      end else if (roll < 60) begin
         it.kind = (roll < 50) ? REQ_APPLY : REQ_RESTORE;
         if (tbl_count != 0 && $urandom_range(9) != 0)
            it.idx = 7'($urandom_range(tbl_count - 1));
         // A restore must not put back a byte that was never captured.
         if (it.kind == REQ_RESTORE && 32'(it.idx) < tbl_count && tbl_en[it.idx]
             && (tbl_code[it.idx] == CODE_BUS || bank_code(tbl_code[it.idx]))
             && !saved_known[it.idx])
            it.kind = REQ_APPLY;
      end else if (roll < 98) begin
         it.kind = REQ_BUS;
         if (applied_addrs.size() != 0 && $urandom_range(99) < 70)
            it.addr = applied_addrs[$urandom_range(applied_addrs.size() - 1)];
         if (owner_of.exists(it.addr)) begin
            owner = owner_of[it.addr];
            if (bank_code(tbl_code[owner]) && $urandom_range(99) < 60)
               it.bank = 3'(tbl_code[owner] - CODE_BANK_LO);
         end
      end else begin
         it.kind = 3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got_v,
                                  input int unsigned want_v);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got_v, want_v);
      mismatch_count++;
   endtask

   task automatic send_request(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {6'd0, it.rdval, it.idx, it.bank, it.wdata, it.addr, it.value, it.code};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(intercept_predict(it));
   endtask

   task automatic send_fields(input logic [2:0] kind, input logic [7:0] code,
                              input logic [7:0] value, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [2:0] bank,
                              input logic [6:0] idx, input logic [7:0] rdval);
      req_item_type it;
      it.kind = kind;
      it.code = code;
      it.value = value;
      it.addr = addr;
      it.wdata = wdata;
      it.bank = bank;
      it.idx = idx;
      it.rdval = rdval;
      send_request(it);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   always @(negedge clock) rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin : check_results
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.write_valid = rsp_tdata[2];
         got.write_target = rsp_tdata[3];
         got.write_address = rsp_tdata[19:4];
         got.write_value = rsp_tdata[27:20];
         got.substituted = rsp_tdata[28];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.write_valid !== want.write_valid)
               report_mismatch("write_valid", 32'(got.write_valid), 32'(want.write_valid));
            if (got.write_target !== want.write_target)
               report_mismatch("write_target", 32'(got.write_target),
                               32'(want.write_target));
            if (got.write_address !== want.write_address)
               report_mismatch("write_address", 32'(got.write_address),
                               32'(want.write_address));
            if (got.write_value !== want.write_value)
               report_mismatch("write_value", 32'(got.write_value), 32'(want.write_value));
            if (got.substituted !== want.substituted)
               report_mismatch("substituted", 32'(got.substituted), 32'(want.substituted));
         end
      end
   end

   task automatic test_directed();
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_RESTORE, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd127, 8'h00);
      send_fields(REQ_ADD, CODE_BUS, 8'hFF, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_ADD, CODE_BANK_LO, 8'h00, WRAM_LO, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_ADD, CODE_BANK_HI, 8'hA5, WRAM_END - 16'd1, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_ADD, CODE_BANK_LO + 8'd3, 8'h5A, 16'hFFFF, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_ADD, CODE_ONCE, 8'h77, 16'hC123, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_ADD, CODE_ODD, 8'h33, WRAM_END, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd1, 8'hFF);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd2, 8'h12);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd3, 8'h34);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd4, 8'h56);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd5, 8'h78);
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd4, 8'h9A);
      send_fields(REQ_RESTORE, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd4, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, 16'h0000, 8'h99, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, WRAM_LO, 8'h42, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, WRAM_END - 16'd1, 8'h24, 3'd3, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, 16'hFFFF, 8'hC3, 3'd7, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, WRAM_END, 8'h3C, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, 16'hC123, 8'h81, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_RESTORE, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd1, 8'h00);
      send_fields(REQ_RESTORE, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd5, 8'h00);
      send_fields(REQ_UNDEF_LO, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 3'd7, 7'd127, 8'hFF);
      send_fields(REQ_UNDEF_HI, 8'h01, 8'h80, 16'h8001, 8'h7E, 3'd5, 7'd64, 8'h81);
      send_fields(REQ_CLEAR, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      send_fields(REQ_BUS, 8'h00, 8'h00, 16'h0000, 8'h99, 3'd0, 7'd0, 8'h00);
      stop_requests();
   endtask

   task automatic test_table_full();
      logic [15:0] last_addr;
      send_fields(REQ_CLEAR, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      repeat (MAX_ENTRIES_DEF + 2) send_request(random_add());
      last_addr = tbl_addr[MAX_ENTRIES_DEF - 1];
      send_fields(REQ_APPLY, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd127, 8'hE7);
      send_fields(REQ_BUS, 8'h00, 8'h00, last_addr, 8'h18, tbl_code[127][2:0], 7'd0, 8'h00);
      send_fields(REQ_RESTORE, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd127, 8'h00);
      send_fields(REQ_CLEAR, 8'h00, 8'h00, 16'h0000, 8'h00, 3'd0, 7'd0, 8'h00);
      stop_requests();
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (40) send_request(random_request());
      join
      stop_requests();
   endtask

   task automatic run_random_phase(input int n, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n) send_request(random_request());
      stop_requests();
   endtask

   task automatic test_random_traffic();
      run_random_phase(300, 31, 62);
      run_random_phase(300, 62, 31);
      run_random_phase(250, 0, 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_output_stall();
      test_random_traffic();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
